// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srtf_pkg.sv =====
// Package with the types and codes of the SRTF scheduler.
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int JOB_W      = 8;
    localparam int BURST_IN_W = 16;
    localparam int STATUS_W   = 3;
    localparam int OUT_T_W    = 32;

    typedef enum logic {
        REQ_ARRIVE = 1'b0,
        REQ_TICK   = 1'b1
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_BURST = 3'd2,
        ST_RAN       = 3'd3,
        ST_IDLE      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [JOB_W-1:0]     ran_id;
        logic [OUT_T_W-1:0]   tick_time;
        logic                 finished;
        logic [OUT_T_W-1:0]   turnaround;
        logic [OUT_T_W-1:0]   waiting;
    } t_res;

endpackage

// ===== rtl/srtf_req_if.sv =====
// Request channel interface of the SRTF scheduler.
`timescale 1ns / 1ps

interface srtf_req_if;
    import srtf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [JOB_W-1:0]      job_id;
    logic [BURST_IN_W-1:0] burst_len;

    modport source (output valid, output req_type, output job_id, output burst_len,
                    input ready);
    modport sink   (input valid, input req_type, input job_id, input burst_len,
                    output ready);
endinterface

// ===== rtl/srtf_res_if.sv =====
// Result channel interface of the SRTF scheduler.
`timescale 1ns / 1ps

interface srtf_res_if;
    import srtf_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [JOB_W-1:0]    ran_id;
    logic [OUT_T_W-1:0]  tick_time;
    logic                finished;
    logic [OUT_T_W-1:0]  turnaround;
    logic [OUT_T_W-1:0]  waiting;

    modport source (output valid, output status, output ran_id, output tick_time,
                    output finished, output turnaround, output waiting, input ready);
    modport sink   (input valid, input status, input ran_id, input tick_time,
                    input finished, input turnaround, input waiting, output ready);
endinterface

// ===== rtl/srtf_scheduler_top.sv =====
// Top level of the preemptive shortest-remaining-time-first job scheduler.
//
//   Channel   Dir   Modport  Transaction
//   i_req     in    sink     one arrival (job_id, burst_len) or one tick
//   o_res     out   source   one result per request: status, run info, times
//
// An arrival is handled in the accept cycle, at whose end its result is registered:
// the lowest free slot is found from the valid flags and both memories are written in
// the accept cycle. For a tick the remaining-time memory is read one slot per cycle
// through its single read port and a single comparator keeps the running minimum;
// then S_LAST reads the winner's record alongside the final compare and S_FIN
// writes its decremented remaining time back.
// Reset clears the valid flags, the time counter and all control state at once;
// the memories need no clearing pass since an entry is only used once it is valid.
// A stalled result keeps the next one in the emit state; requests wait for S_IDLE.
`timescale 1ns / 1ps

module srtf_scheduler_top #(
    parameter int SLOTS      = 16,
    parameter int TIME_BITS  = 32,
    parameter int BURST_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srtf_req_if.sink     i_req,
    srtf_res_if.source   o_res
);
    import srtf_pkg::*;

    localparam int IW     = $clog2(SLOTS);
    localparam int INFO_W = JOB_W + BURST_BITS + TIME_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // Control registers.
    t_state               r_state, n_state;
    logic [SLOTS-1:0]     r_valid, n_valid;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic                 r_best_vld, n_best_vld;
    logic                 r_o_valid, n_o_valid;

    // Working and payload registers.
    logic [TIME_BITS-1:0]  r_tick_t, n_tick_t;
    logic [IW-1:0]         r_scan, n_scan;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic [IW-1:0]         r_best, n_best;
    logic [BURST_BITS-1:0] r_best_rem, n_best_rem;
    t_res                  r_res, n_res;
    t_res                  r_o_res, n_o_res;

    // Memory ports.
    logic                  mem_we_rem;
    logic                  mem_we_info;
    logic [IW-1:0]         mem_waddr;
    logic [IW-1:0]         mem_raddr;
    logic [BURST_BITS-1:0] rem_wdata, rem_rdata;
    logic [INFO_W-1:0]     info_wdata, info_rdata;

    // Decoded request and helpers.
    logic                  in_acc;
    logic                  out_free;
    logic [BURST_BITS-1:0] burst_w;
    logic [IW-1:0]         free_idx;
    logic                  have_free;
    logic                  take;
    logic [JOB_W-1:0]      info_job;
    logic [BURST_BITS-1:0] info_burst;
    logic [TIME_BITS-1:0]  info_arr;
    logic [BURST_BITS-1:0] rem_new;
    logic [TIME_BITS-1:0]  turn_t, wait_t;
    logic [63:0]           tick64, turn64, wait64;

    // Remaining time per slot, read once per slot during the scan.
    srtf_ram #(.WIDTH(BURST_BITS), .DEPTH(SLOTS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we_rem),
        .i_waddr (mem_waddr),
        .i_wdata (rem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rem_rdata)
    );

    // Job id, burst and arrival stamp per slot, read once for the winner.
    srtf_ram #(.WIDTH(INFO_W), .DEPTH(SLOTS)) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we_info),
        .i_waddr (mem_waddr),
        .i_wdata (info_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (info_rdata)
    );

    assign in_acc   = i_req.valid && i_req.ready;
    assign out_free = !r_o_valid || o_res.ready;
    assign burst_w  = BURST_BITS'(i_req.burst_len);

    // Lowest free slot from the valid flags.
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
    end
    assign have_free = ~&r_valid;

    // The slot whose data just came back replaces the best one only when strictly
    // smaller, so ties keep the lower slot.
    assign take = r_valid[r_rd_idx] && (!r_best_vld || (rem_rdata < r_best_rem));

    assign info_job   = info_rdata[INFO_W-1 -: JOB_W];
    assign info_burst = info_rdata[TIME_BITS +: BURST_BITS];
    assign info_arr   = info_rdata[TIME_BITS-1:0];
    assign rem_new    = r_best_rem - BURST_BITS'(1);
    // r_now has already been advanced, so it holds the finish time here.
    assign turn_t     = r_now - info_arr;
    assign wait_t     = turn_t - TIME_BITS'(info_burst);
    assign tick64     = 64'(r_tick_t);
    assign turn64     = 64'(turn_t);
    assign wait64     = 64'(wait_t);

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_now      = r_now;
        n_best_vld = r_best_vld;
        n_o_valid  = r_o_valid;
        n_tick_t   = r_tick_t;
        n_scan     = r_scan;
        n_rd_idx   = r_rd_idx;
        n_best     = r_best;
        n_best_rem = r_best_rem;
        n_res      = r_res;
        n_o_res    = r_o_res;

        mem_we_rem  = 1'b0;
        mem_we_info = 1'b0;
        mem_waddr   = free_idx;
        mem_raddr   = r_scan;
        rem_wdata   = burst_w;
        info_wdata  = {i_req.job_id, burst_w, r_now};

        if (r_o_valid && o_res.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req.req_type == REQ_TICK) begin
                        n_tick_t   = r_now;
                        n_now      = r_now + TIME_BITS'(1);
                        mem_raddr  = '0;
                        n_rd_idx   = '0;
                        n_scan     = IW'(1);
                        n_best_vld = 1'b0;
                        n_state    = S_SCAN;
                    end else begin
                        n_res = '0;
                        if (burst_w == '0) begin
                            n_res.status = ST_BAD_BURST;
                        end else if (!have_free) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_res.status      = ST_ACCEPTED;
                            mem_we_rem        = 1'b1;
                            mem_we_info       = 1'b1;
                            n_valid[free_idx] = 1'b1;
                        end
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                mem_raddr = r_scan;
                n_rd_idx  = r_scan;
                if (take) begin
                    n_best     = r_rd_idx;
                    n_best_rem = rem_rdata;
                    n_best_vld = 1'b1;
                end
                if (r_scan == LAST_IDX) begin
                    n_state = S_LAST;
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end
            S_LAST: begin
                // Final compare; the winner's record is read right away.
                mem_raddr = r_best;
                if (take) begin
                    n_best     = r_rd_idx;
                    n_best_rem = rem_rdata;
                    n_best_vld = 1'b1;
                    mem_raddr  = r_rd_idx;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                mem_raddr       = r_best;
                n_res           = '0;
                n_res.tick_time = tick64[OUT_T_W-1:0];
                if (!r_best_vld) begin
                    n_res.status = ST_IDLE;
                end else begin
                    n_res.status = ST_RAN;
                    n_res.ran_id = info_job;
                    mem_we_rem   = 1'b1;
                    mem_waddr    = r_best;
                    rem_wdata    = rem_new;
                    if (rem_new == '0) begin
                        n_valid[r_best]  = 1'b0;
                        n_res.finished   = 1'b1;
                        n_res.turnaround = turn64[OUT_T_W-1:0];
                        n_res.waiting    = wait64[OUT_T_W-1:0];
                    end
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_res   = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_now      <= '0;
            r_best_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_now      <= n_now;
            r_best_vld <= n_best_vld;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick_t   <= n_tick_t;
        r_scan     <= n_scan;
        r_rd_idx   <= n_rd_idx;
        r_best     <= n_best;
        r_best_rem <= n_best_rem;
        r_res      <= n_res;
        r_o_res    <= n_o_res;
    end

    assign i_req.ready      = (r_state == S_IDLE) && i_rst_n;
    assign o_res.valid      = r_o_valid;
    assign o_res.status     = r_o_res.status;
    assign o_res.ran_id     = r_o_res.ran_id;
    assign o_res.tick_time  = r_o_res.tick_time;
    assign o_res.finished   = r_o_res.finished;
    assign o_res.turnaround = r_o_res.turnaround;
    assign o_res.waiting    = r_o_res.waiting;
endmodule

// ===== rtl/srtf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/srtf_checker.sv =====
// Port-level checker of the SRTF scheduler and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srtf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [srtf_pkg::STATUS_W-1:0]  i_status,
    input logic [srtf_pkg::JOB_W-1:0]     i_ran_id,
    input logic [srtf_pkg::OUT_T_W-1:0]   i_tick_time,
    input logic                           i_finished,
    input logic [srtf_pkg::OUT_T_W-1:0]   i_turnaround,
    input logic [srtf_pkg::OUT_T_W-1:0]   i_waiting
);
    import srtf_pkg::*;

    // A result stays offered until the sink takes it.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // The scheduler works on one request at a time.
    `CHK_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request accepted while busy")

    // Only a tick that ran a job can report a completion.
    `CHK_IMPLY(a_finish_on_run, i_clk, i_rst_n, i_out_valid && i_finished, i_status == ST_RAN, "completion without a run")

    // Arrival results carry no run or time information.
    `CHK_IMPLY(a_arrival_clean, i_clk, i_rst_n, i_out_valid && i_status != ST_RAN && i_status != ST_IDLE, i_ran_id == '0 && i_tick_time == '0 && !i_finished && i_turnaround == '0 && i_waiting == '0, "arrival result has tick fields")
endmodule

bind srtf_scheduler_top srtf_checker u_srtf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_ran_id     (o_res.ran_id),
    .i_tick_time  (o_res.tick_time),
    .i_finished   (o_res.finished),
    .i_turnaround (o_res.turnaround),
    .i_waiting    (o_res.waiting)
);
